// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers; clk and rst_n come from the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PEWS_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pews assertion failed");

// next-cycle implication
`define PEWS_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pews assertion failed");

`endif

// ----- hw/rtl/pews_pkg.sv -----
`timescale 1ns / 1ps
package pews_pkg;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE      = 5'd0;
  localparam op_t OP_CAPTURE   = 5'd1;
  localparam op_t OP_START     = 5'd2;
  localparam op_t OP_MOD       = 5'd3;
  localparam op_t OP_MODFIN    = 5'd4;
  localparam op_t OP_ADDINIT   = 5'd5;
  localparam op_t OP_SQA       = 5'd6;
  localparam op_t OP_SQB       = 5'd7;
  localparam op_t OP_SQRT      = 5'd8;
  localparam op_t OP_SQFIN     = 5'd9;
  localparam op_t OP_DIVINIT   = 5'd10;
  localparam op_t OP_DIV       = 5'd11;
  localparam op_t OP_DIVFIN    = 5'd12;
  localparam op_t OP_REQ       = 5'd13;
  localparam op_t OP_SEEKRD    = 5'd14;
  localparam op_t OP_SEEKADD   = 5'd15;
  localparam op_t OP_PLLD      = 5'd16;
  localparam op_t OP_PLMUL     = 5'd17;
  localparam op_t OP_PLPOS     = 5'd18;
  localparam op_t OP_CORD      = 5'd19;
  localparam op_t OP_ROTFIN    = 5'd20;
  localparam op_t OP_EMIT_HIT  = 5'd21;
  localparam op_t OP_EMIT_MISS = 5'd22;

  localparam logic [4:0] MOD_STEPS    = 5'd23;
  localparam logic [4:0] SQRT_STEPS   = 5'd26;
  localparam logic [4:0] DIV_STEPS    = 5'd18;
  localparam logic [4:0] CORDIC_STEPS = 5'd14;

  localparam logic CFG_START_OFFSET  = 1'b0;
  localparam logic CFG_POINT_SPACING = 1'b1;

  localparam logic signed [16:0] ROT_HALF_PI = 17'sd12868;
  localparam logic signed [16:0] ROT_PI      = 17'sd25736;
  localparam logic signed [16:0] ROT_MIN     = -17'sd12868;
  localparam logic signed [16:0] ROT_MAX     = 17'sd38605;

  typedef struct packed {
    op_t        op;
    logic [4:0] iter;
  } dp_cmd_t;

  typedef struct packed {
    logic is_load;
    logic is_first;
    logic vc_zero;
    logic vc_room;
    logic walk;
    logic rem_gt_s;
    logic start_pos;
    logic seek_go;
    logic seek_miss;
    logic out_free;
  } dp_stat_t;

  function automatic logic signed [17:0] atan_q13(input logic [3:0] i);
    logic signed [17:0] v;
    unique case (i)
      4'd0:    v = 18'sd6434;
      4'd1:    v = 18'sd3798;
      4'd2:    v = 18'sd2007;
      4'd3:    v = 18'sd1019;
      4'd4:    v = 18'sd511;
      4'd5:    v = 18'sd256;
      4'd6:    v = 18'sd128;
      4'd7:    v = 18'sd64;
      4'd8:    v = 18'sd32;
      4'd9:    v = 18'sd16;
      4'd10:   v = 18'sd8;
      4'd11:   v = 18'sd4;
      4'd12:   v = 18'sd2;
      4'd13:   v = 18'sd1;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/pews_ram.sv -----
`timescale 1ns / 1ps
module pews_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/pews_ctrl.sv -----
`timescale 1ns / 1ps
module pews_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pews_pkg::dp_stat_t stat,
  output pews_pkg::dp_cmd_t  cmd
);
  import pews_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DEC     = 5'd1;
  localparam logic [4:0] S_MOD     = 5'd2;
  localparam logic [4:0] S_MODFIN  = 5'd3;
  localparam logic [4:0] S_SQA     = 5'd4;
  localparam logic [4:0] S_SQB     = 5'd5;
  localparam logic [4:0] S_SQRT    = 5'd6;
  localparam logic [4:0] S_SQFIN   = 5'd7;
  localparam logic [4:0] S_DIVINIT = 5'd8;
  localparam logic [4:0] S_DIV     = 5'd9;
  localparam logic [4:0] S_DIVFIN  = 5'd10;
  localparam logic [4:0] S_SEEK    = 5'd11;
  localparam logic [4:0] S_SEEKADD = 5'd12;
  localparam logic [4:0] S_PLLD    = 5'd13;
  localparam logic [4:0] S_PLMUL   = 5'd14;
  localparam logic [4:0] S_PLPOS   = 5'd15;
  localparam logic [4:0] S_CORD    = 5'd16;
  localparam logic [4:0] S_ROT     = 5'd17;
  localparam logic [4:0] S_HIT     = 5'd18;
  localparam logic [4:0] S_MISS    = 5'd19;

  logic [4:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = 5'd0;
    cmd.op    = OP_NONE;
    cmd.iter  = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.is_load) begin
          if (stat.is_first || stat.vc_zero) begin
            cmd.op    = OP_START;
            state_nxt = stat.start_pos ? S_MOD : S_IDLE;
          end else if (stat.vc_room) begin
            cmd.op    = OP_ADDINIT;
            state_nxt = S_SQA;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.op = OP_REQ;
          if (stat.walk && stat.rem_gt_s) state_nxt = S_PLLD;
          else state_nxt = S_SEEK;
        end
      end
      S_MOD: begin
        cmd.op = OP_MOD;
        if (cnt_r == MOD_STEPS - 5'd1) state_nxt = S_MODFIN;
        else cnt_nxt = cnt_r + 5'd1;
      end
      S_MODFIN: begin
        cmd.op    = OP_MODFIN;
        state_nxt = S_IDLE;
      end
      S_SQA: begin
        cmd.op    = OP_SQA;
        state_nxt = S_SQB;
      end
      S_SQB: begin
        cmd.op    = OP_SQB;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (cnt_r == SQRT_STEPS - 5'd1) state_nxt = S_SQFIN;
        else cnt_nxt = cnt_r + 5'd1;
      end
      S_SQFIN: begin
        cmd.op    = OP_SQFIN;
        state_nxt = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd.op    = OP_DIVINIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (cnt_r == DIV_STEPS - 5'd1) state_nxt = S_DIVFIN;
        else cnt_nxt = cnt_r + 5'd1;
      end
      S_DIVFIN: begin
        cmd.op    = OP_DIVFIN;
        state_nxt = S_IDLE;
      end
      S_SEEK: begin
        if (stat.seek_go) begin
          cmd.op    = OP_SEEKRD;
          state_nxt = S_SEEKADD;
        end else if (stat.seek_miss) begin
          state_nxt = S_MISS;
        end else begin
          state_nxt = S_PLLD;
        end
      end
      S_SEEKADD: begin
        cmd.op    = OP_SEEKADD;
        state_nxt = S_SEEK;
      end
      S_PLLD: begin
        cmd.op    = OP_PLLD;
        state_nxt = S_PLMUL;
      end
      S_PLMUL: begin
        cmd.op    = OP_PLMUL;
        state_nxt = S_PLPOS;
      end
      S_PLPOS: begin
        cmd.op    = OP_PLPOS;
        state_nxt = S_CORD;
      end
      S_CORD: begin
        cmd.op = OP_CORD;
        if (cnt_r == CORDIC_STEPS - 5'd1) state_nxt = S_ROT;
        else cnt_nxt = cnt_r + 5'd1;
      end
      S_ROT: begin
        cmd.op    = OP_ROTFIN;
        state_nxt = S_HIT;
      end
      S_HIT: begin
        if (stat.out_free) begin
          cmd.op    = OP_EMIT_HIT;
          state_nxt = S_IDLE;
        end
      end
      S_MISS: begin
        if (stat.out_free) begin
          cmd.op    = OP_EMIT_MISS;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end
endmodule

// ----- hw/rtl/pews_dp.sv -----
`timescale 1ns / 1ps
module pews_dp #(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pews_pkg::dp_cmd_t   cmd,
  output pews_pkg::dp_stat_t  stat,
  input  logic                in_kind,
  input  logic signed [23:0]  in_vertex_x,
  input  logic signed [23:0]  in_vertex_y,
  input  logic                in_first_vertex,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_found,
  output logic signed [23:0]  out_point_x,
  output logic signed [23:0]  out_point_y,
  output logic signed [16:0]  out_rotation
);
  import pews_pkg::*;

  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int SEG_W  = ADDR_W + 1;
  localparam int REM_W  = (COORD_BITS + 2 > 26) ? COORD_BITS + 2 : 26;
  localparam int LEN_W  = COORD_BITS;
  localparam int DIS_W  = COORD_BITS + 1;
  localparam int PRD_W  = DIS_W + 16;
  localparam int SUM_W  = (COORD_BITS + 4 > 26) ? COORD_BITS + 4 : 26;

  localparam logic signed [REM_W:0] RMAX =
    {{(REM_W + 1 - COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};
  localparam logic signed [REM_W:0] RMIN = ~RMAX;
  localparam logic [32:0] LEN_LIM = (33'd1 << COORD_BITS) - 33'd1;
  localparam logic signed [SUM_W-1:0] FMAX = SUM_W'(24'sh7fffff);
  localparam logic signed [SUM_W-1:0] FMIN = ~FMAX;
  localparam logic signed [17:0] RMAX18 = 18'(ROT_MAX);
  localparam logic signed [17:0] RMIN18 = 18'(ROT_MIN);

  function automatic logic signed [15:0] dir_sat(input logic [17:0] q, input logic neg);
    logic [17:0] nq;
    nq = -q;
    if (neg) return (q > 18'd32768) ? 16'sh8000 : nq[15:0];
    return (q > 18'd32767) ? 16'sh7fff : q[15:0];
  endfunction

  function automatic logic signed [23:0] place_coord(input logic signed [23:0] pv,
                                                     input logic signed [PRD_W-1:0] p);
    logic [PRD_W-1:0]        mag;
    logic [PRD_W-1:0]        qu;
    logic signed [SUM_W-1:0] q;
    logic signed [SUM_W-1:0] sum;
    mag = p[PRD_W-1] ? PRD_W'(-p) : PRD_W'(p);
    qu  = (mag + PRD_W'(16384)) >> 15;
    q   = $signed(SUM_W'(qu));
    if (p[PRD_W-1]) q = -q;
    sum = SUM_W'(pv) + q;
    if (sum > FMAX) return 24'sh7fffff;
    if (sum < FMIN) return 24'sh800000;
    return sum[23:0];
  endfunction

  // config and captured item
  logic signed [23:0] so_r;
  logic [22:0]        ps_r;
  logic               kind_r, first_r;
  logic signed [23:0] ix_r, iy_r;

  // walk state
  logic [CNT_W-1:0]        vc_r;
  logic signed [SEG_W-1:0] seg_r;
  logic signed [REM_W-1:0] rem_r;
  logic                    walk_r;
  logic signed [23:0]      lastx_r, lasty_r;

  // load arithmetic
  logic signed [24:0] dx_r, dy_r;
  logic [49:0]        sq_r;
  logic [51:0]        n_r, sr_r, sbit_r;
  logic [25:0]        len_r;
  logic [27:0]        remx_r, remy_r;
  logic [17:0]        nlox_r, nloy_r, qx_r, qy_r;
  logic [23:0]        mr_r;
  logic [22:0]        md_r;

  // placement
  logic signed [15:0]      pux_r, puy_r;
  logic signed [23:0]      pvx_r, pvy_r;
  logic signed [DIS_W-1:0] dis_r;
  logic signed [PRD_W-1:0] prx_r, pry_r;
  logic signed [23:0]      ptx_r, pty_r;
  logic signed [27:0]      cx_r, cy_r;
  logic signed [17:0]      cz_r;
  logic                    base_r;
  logic signed [16:0]      rot_r;

  // output register
  logic               ov_r, of_r;
  logic signed [23:0] ox_r, oy_r;
  logic signed [16:0] orot_r;

  // memories
  logic [ADDR_W-1:0] rd_addr, v_waddr, l_waddr;
  logic              v_we, l_we;
  logic [47:0]       v_rd;
  logic [LEN_W-1:0]  l_rd, len_sat;
  logic [31:0]       d_rd;

  // combinational helpers
  logic [22:0]               s_val;
  logic signed [REM_W-1:0]   s_ext;
  logic signed [CNT_W+1:0]   seg_w, nseg_w;
  logic signed [REM_W:0]     rem_sub;
  logic signed [24:0]        nso;
  logic [23:0]               mod_t;
  logic [27:0]               tx, ty;
  logic [51:0]               r_plus;
  logic [24:0]               magx, magy;
  logic [39:0]               numx, numy;
  logic signed [49:0]        dxsq, dysq;
  logic signed [15:0]        ux_c, uy_c;
  logic signed [27:0]        ux_s, uy_s, cx_sh, cy_sh;
  logic signed [17:0]        rsum, atv;

  always_comb begin
    s_val   = (ps_r == 23'd0) ? 23'd1 : ps_r;
    s_ext   = $signed({{(REM_W - 23){1'b0}}, s_val});
    seg_w   = $signed({{(CNT_W + 2 - SEG_W){seg_r[SEG_W-1]}}, seg_r}) + 2'sd1;
    nseg_w  = (vc_r == '0) ? '0 : $signed({2'b00, vc_r}) - 2'sd1;
    rem_sub = {rem_r[REM_W-1], rem_r} - {s_ext[REM_W-1], s_ext};
    nso     = -$signed({so_r[23], so_r});
    mod_t   = {mr_r[22:0], md_r[22]};
    tx      = {remx_r[26:0], nlox_r[17]};
    ty      = {remy_r[26:0], nloy_r[17]};
    r_plus  = sr_r + sbit_r;
    magx    = dx_r[24] ? 25'(-dx_r) : 25'(dx_r);
    magy    = dy_r[24] ? 25'(-dy_r) : 25'(dy_r);
    numx    = {magx, 15'd0} + {15'd0, len_r[25:1]};
    numy    = {magy, 15'd0} + {15'd0, len_r[25:1]};
    dxsq    = dx_r * dx_r;
    dysq    = dy_r * dy_r;
    if (len_r == 26'd0) begin
      ux_c = 16'sd0;
      uy_c = 16'sd0;
    end else begin
      ux_c = dir_sat(qx_r, dx_r[24]);
      uy_c = dir_sat(qy_r, dy_r[24]);
    end
    if ({7'd0, len_r} > LEN_LIM) len_sat = '1;
    else len_sat = LEN_W'(len_r);
    ux_s  = {{4{pux_r[15]}}, pux_r, 8'd0};
    uy_s  = {{4{puy_r[15]}}, puy_r, 8'd0};
    cx_sh = cx_r >>> cmd.iter[3:0];
    cy_sh = cy_r >>> cmd.iter[3:0];
    atv   = atan_q13(cmd.iter[3:0]);
    rsum  = (base_r ? 18'(ROT_PI) : 18'sd0) + cz_r;
  end

  assign rd_addr = (cmd.op == OP_SEEKRD) ? seg_w[ADDR_W-1:0] : seg_r[ADDR_W-1:0];
  assign v_we    = (cmd.op == OP_START) || (cmd.op == OP_DIVFIN);
  assign v_waddr = (cmd.op == OP_START) ? '0 : vc_r[ADDR_W-1:0];
  assign l_we    = (cmd.op == OP_DIVFIN);
  assign l_waddr = ADDR_W'(vc_r - CNT_W'(1));

  pews_ram #(.WIDTH(48), .DEPTH(MAX_VERTICES)) u_vram (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata({ix_r, iy_r}),
    .raddr(rd_addr), .rdata(v_rd)
  );
  pews_ram #(.WIDTH(LEN_W), .DEPTH(MAX_VERTICES)) u_lram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(len_sat),
    .raddr(rd_addr), .rdata(l_rd)
  );
  pews_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_dram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata({ux_c, uy_c}),
    .raddr(rd_addr), .rdata(d_rd)
  );

  always_comb begin
    stat.is_load   = !kind_r;
    stat.is_first  = first_r;
    stat.vc_zero   = (vc_r == '0);
    stat.vc_room   = (vc_r < CNT_W'(MAX_VERTICES));
    stat.walk      = walk_r;
    stat.rem_gt_s  = (rem_r > s_ext);
    stat.start_pos = so_r[23];
    stat.seek_go   = (rem_r <= 0) && (seg_w < nseg_w);
    stat.seek_miss = seg_r[SEG_W-1] || rem_r[REM_W-1];
    stat.out_free  = !ov_r || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      so_r   <= 24'sd0;
      ps_r   <= 23'd256;
      vc_r   <= '0;
      seg_r  <= '1;
      rem_r  <= '0;
      walk_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_START_OFFSET) so_r <= $signed(cfg_data);
        else ps_r <= cfg_data[22:0];
      end
      // a new item may load the output register as the old one leaves
      if (cmd.op == OP_EMIT_HIT || cmd.op == OP_EMIT_MISS) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
      unique case (cmd.op)
        OP_START: begin
          vc_r   <= CNT_W'(1);
          seg_r  <= '1;
          walk_r <= 1'b0;
          rem_r  <= REM_W'(nso);
        end
        OP_MODFIN: begin
          rem_r <= $signed({{(REM_W - 24){1'b0}}, mr_r}) + 2'sd1 - s_ext;
        end
        OP_DIVFIN: begin
          vc_r <= vc_r + CNT_W'(1);
        end
        OP_REQ: begin
          if (!walk_r) begin
            walk_r <= 1'b1;
          end else if (rem_r > s_ext) begin
            rem_r <= rem_r - s_ext;
          end else if (rem_sub > RMAX) begin
            rem_r <= REM_W'(RMAX);
          end else if (rem_sub < RMIN) begin
            rem_r <= REM_W'(RMIN);
          end else begin
            rem_r <= REM_W'(rem_sub);
          end
        end
        OP_SEEKRD: begin
          seg_r <= SEG_W'(seg_w);
        end
        OP_SEEKADD: begin
          rem_r <= rem_r + $signed({{(REM_W - LEN_W){1'b0}}, l_rd});
        end
        default: begin
        end
      endcase
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: begin
        kind_r  <= in_kind;
        first_r <= in_first_vertex;
        ix_r    <= in_vertex_x;
        iy_r    <= in_vertex_y;
      end
      OP_START: begin
        lastx_r <= ix_r;
        lasty_r <= iy_r;
        md_r    <= 23'(nso - 25'sd1);
        mr_r    <= 24'd0;
      end
      OP_MOD: begin
        md_r <= md_r << 1;
        mr_r <= (mod_t >= {1'b0, s_val}) ? mod_t - {1'b0, s_val} : mod_t;
      end
      OP_ADDINIT: begin
        dx_r <= $signed({ix_r[23], ix_r}) - $signed({lastx_r[23], lastx_r});
        dy_r <= $signed({iy_r[23], iy_r}) - $signed({lasty_r[23], lasty_r});
      end
      OP_SQA: begin
        sq_r <= $unsigned(dxsq);
      end
      OP_SQB: begin
        n_r    <= {2'b00, sq_r} + {2'b00, $unsigned(dysq)};
        sr_r   <= 52'd0;
        sbit_r <= 52'd1 << 50;
      end
      OP_SQRT: begin
        if (n_r >= r_plus) begin
          n_r  <= n_r - r_plus;
          sr_r <= (sr_r >> 1) + sbit_r;
        end else begin
          sr_r <= sr_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
      end
      OP_SQFIN: begin
        len_r <= (n_r > sr_r) ? 26'(sr_r + 52'd1) : 26'(sr_r);
      end
      OP_DIVINIT: begin
        remx_r <= {6'd0, numx[39:18]};
        remy_r <= {6'd0, numy[39:18]};
        nlox_r <= numx[17:0];
        nloy_r <= numy[17:0];
        qx_r   <= 18'd0;
        qy_r   <= 18'd0;
      end
      OP_DIV: begin
        nlox_r <= nlox_r << 1;
        nloy_r <= nloy_r << 1;
        if (tx >= {2'b00, len_r}) begin
          remx_r <= tx - {2'b00, len_r};
          qx_r   <= {qx_r[16:0], 1'b1};
        end else begin
          remx_r <= tx;
          qx_r   <= {qx_r[16:0], 1'b0};
        end
        if (ty >= {2'b00, len_r}) begin
          remy_r <= ty - {2'b00, len_r};
          qy_r   <= {qy_r[16:0], 1'b1};
        end else begin
          remy_r <= ty;
          qy_r   <= {qy_r[16:0], 1'b0};
        end
      end
      OP_DIVFIN: begin
        lastx_r <= ix_r;
        lasty_r <= iy_r;
      end
      OP_PLLD: begin
        pvx_r <= $signed(v_rd[47:24]);
        pvy_r <= $signed(v_rd[23:0]);
        pux_r <= $signed(d_rd[31:16]);
        puy_r <= $signed(d_rd[15:0]);
        dis_r <= DIS_W'($signed({{(REM_W + 1 - LEN_W){1'b0}}, l_rd})
                        - $signed({rem_r[REM_W-1], rem_r}));
      end
      OP_PLMUL: begin
        prx_r  <= pux_r * dis_r;
        pry_r  <= puy_r * dis_r;
        base_r <= pux_r[15];
        cx_r   <= pux_r[15] ? -ux_s : ux_s;
        cy_r   <= pux_r[15] ? -uy_s : uy_s;
        cz_r   <= 18'sd0;
      end
      OP_PLPOS: begin
        ptx_r <= place_coord(pvx_r, prx_r);
        pty_r <= place_coord(pvy_r, pry_r);
      end
      OP_CORD: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + cy_sh;
          cy_r <= cy_r - cx_sh;
          cz_r <= cz_r + atv;
        end else begin
          cx_r <= cx_r - cy_sh;
          cy_r <= cy_r + cx_sh;
          cz_r <= cz_r - atv;
        end
      end
      OP_ROTFIN: begin
        if (pux_r == 16'sd0) begin
          rot_r <= (puy_r > 16'sd0) ? ROT_HALF_PI : -ROT_HALF_PI;
        end else if (puy_r == 16'sd0) begin
          rot_r <= (pux_r > 16'sd0) ? 17'sd0 : ROT_PI;
        end else if (rsum > RMAX18) begin
          rot_r <= ROT_MAX;
        end else if (rsum < RMIN18) begin
          rot_r <= ROT_MIN;
        end else begin
          rot_r <= rsum[16:0];
        end
      end
      OP_EMIT_HIT: begin
        of_r   <= 1'b1;
        ox_r   <= ptx_r;
        oy_r   <= pty_r;
        orot_r <= rot_r;
      end
      OP_EMIT_MISS: begin
        of_r   <= 1'b0;
        ox_r   <= 24'sd0;
        oy_r   <= 24'sd0;
        orot_r <= 17'sd0;
      end
      default: begin
      end
    endcase
  end

  assign out_valid    = ov_r;
  assign out_found    = of_r;
  assign out_point_x  = ox_r;
  assign out_point_y  = oy_r;
  assign out_rotation = orot_r;
endmodule

// ----- hw/rtl/polyline_even_spacing_walker.sv -----
`timescale 1ns / 1ps
// A first-vertex load stores the vertex; with a negative start offset it also runs a 23-step modulo.
// An added vertex, if the store has room, runs a 26-step square root, then an 18-step divide for both axes.
// A request places a point on the current segment or after a search that adds one segment
// length per segment skipped, then runs a 14-step CORDIC loop; an exhausted line gives a miss.
// One item at a time; a result waiting in the output register holds only the next emit.
// Synchronous active-low reset initialises control state; stores are not cleared.
module polyline_even_spacing_walker #(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic signed [23:0] in_vertex_x,
  input  logic signed [23:0] in_vertex_y,
  input  logic               in_first_vertex,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic signed [23:0] out_point_x,
  output logic signed [23:0] out_point_y,
  output logic signed [16:0] out_rotation,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_data
);
  import pews_pkg::*;
`include "assert_macros.svh"

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // config writes are always taken and land at once; the sender keeps them to idle time
  assign cfg_ready = 1'b1;

  // sequencer: decodes each item and steps the shared iterative units
  pews_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // datapath: vertex/length/direction stores, sqrt, dividers, CORDIC, output register
  pews_dp #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_kind        (in_kind),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_first_vertex(in_first_vertex),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_rotation   (out_rotation)
  );

  // a taken item moves the sequencer out of idle, which drops in_ready
  `PEWS_AST_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // a miss carries all-zero fields
  `PEWS_AST_IMP(a_miss_zero, out_valid && !out_found,
                out_point_x == 24'sd0 && out_point_y == 24'sd0 && out_rotation == 17'sd0)
  // placed points carry an angle inside the wrapped range
  `PEWS_AST_IMP(a_rot_range, out_valid && out_found,
                out_rotation >= ROT_MIN && out_rotation <= ROT_MAX)
endmodule
